@@ rtl/quicksort_median_of_three_assert.svh @@
// Assertion macros shared by the sort block. Each expects clk and arst_n in scope.
`ifndef QUICKSORT_MEDIAN_OF_THREE_ASSERT_SVH
`define QUICKSORT_MEDIAN_OF_THREE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define QSM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sort block check failed");

// Consequent must hold in the same cycle as the antecedent.
`define QSM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sort block check failed");

// Consequent must hold in the cycle after the antecedent.
`define QSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sort block check failed");

`endif

@@ rtl/qsm_pkg.sv @@
package qsm_pkg;

	localparam int QSM_MAX_ITEMS  = 64;
	localparam int QSM_DATA_WIDTH = 32;

	// Sequencer states, one-hot.
	typedef enum logic [15:0] {
		ST_LOAD   = 16'h0001,
		ST_POP    = 16'h0002,
		ST_POPW   = 16'h0004,
		ST_M_RD   = 16'h0008,
		ST_M_WR   = 16'h0010,
		ST_P_RD   = 16'h0020,
		ST_P_CMP  = 16'h0040,
		ST_P_SW1  = 16'h0080,
		ST_P_SW2  = 16'h0100,
		ST_F_RD   = 16'h0200,
		ST_F_SW   = 16'h0400,
		ST_F_WR   = 16'h0800,
		ST_PUSH   = 16'h1000,
		ST_E_RD   = 16'h2000,
		ST_E_LD   = 16'h4000,
		ST_E_HOLD = 16'h8000
	} qsm_state_t;

endpackage

@@ rtl/qsm_load_if.sv @@
interface qsm_load_if #(
	parameter int DATA_WIDTH = qsm_pkg::QSM_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

@@ rtl/qsm_result_if.sv @@
interface qsm_result_if #(
	parameter int DATA_WIDTH = qsm_pkg::QSM_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sorted_value;
	logic                         last_out;
	logic                         truncated;

	modport source (output valid, output sorted_value, output last_out, output truncated,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input truncated,
		output ready);
endinterface

@@ rtl/quicksort_median_of_three.sv @@
// Loading accepts one beat per cycle; the block takes no beat while a set is sorted or sent.
// Results leave one at a time: each is read from the registered element memory and held
// until it is taken, and the next one is not read before then.
// Reset (arst_n, asynchronous, active low) empties the set and clears the overflow mark.
module quicksort_median_of_three #(
	parameter int MAX_ITEMS  = qsm_pkg::QSM_MAX_ITEMS,
	parameter int DATA_WIDTH = qsm_pkg::QSM_DATA_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	qsm_load_if.sink     load,
	qsm_result_if.source result
);

	// Index width of both memories. The range stack is as deep as the element
	// store, which is ample: pending ranges are disjoint and hold two or more
	// elements each.
	localparam int IW = $clog2(MAX_ITEMS);

	// Element memory port signals.
	logic                  e_we;
	logic [IW-1:0]         e_waddr;
	logic [DATA_WIDTH-1:0] e_wdata;
	logic [IW-1:0]         e_raddr;
	logic [DATA_WIDTH-1:0] e_rdata;

	// Range stack port signals; each entry packs the low bound above the high bound.
	logic                  s_we;
	logic [IW-1:0]         s_waddr;
	logic [2*IW-1:0]       s_wdata;
	logic [IW-1:0]         s_raddr;
	logic [2*IW-1:0]       s_rdata;

	// The sequencer owns every access to both memories. It loads beats into the element memory,
	// then for each range popped from the stack it reads the first, middle and last entries,
	// writes back the smallest first, the largest in the middle and the median last (the smaller
	// value of a pair), walks the range with a Lomuto split and pushes sub-ranges of two or more.
	qsm_ctrl #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.result  (result),
		.e_we    (e_we),
		.e_waddr (e_waddr),
		.e_wdata (e_wdata),
		.e_raddr (e_raddr),
		.e_rdata (e_rdata),
		.s_we    (s_we),
		.s_waddr (s_waddr),
		.s_wdata (s_wdata),
		.s_raddr (s_raddr),
		.s_rdata (s_rdata)
	);

	// Element store: one value per beat that finds room, sorted in place.
	qsm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_ITEMS)
	) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Range stack: replaces the recursion of the sort.
	qsm_ram #(
		.WIDTH (2 * IW),
		.DEPTH (MAX_ITEMS)
	) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

endmodule

@@ rtl/qsm_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module qsm_ram #(
	parameter int WIDTH = qsm_pkg::QSM_DATA_WIDTH,
	parameter int DEPTH = qsm_pkg::QSM_MAX_ITEMS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/qsm_ctrl.sv @@
// Sequencer: loads the set, runs the quicksort over the element memory with the
// range stack in a second memory, then streams the sorted set out.
// Reads and writes are never issued in the same cycle, so no entry is read while
// it is being written.
module qsm_ctrl #(
	parameter int MAX_ITEMS  = qsm_pkg::QSM_MAX_ITEMS,
	parameter int DATA_WIDTH = qsm_pkg::QSM_DATA_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	qsm_load_if.sink                            load,
	qsm_result_if.source                        result,
	output logic                                e_we,
	output logic [$clog2(MAX_ITEMS)-1:0]        e_waddr,
	output logic [DATA_WIDTH-1:0]               e_wdata,
	output logic [$clog2(MAX_ITEMS)-1:0]        e_raddr,
	input  logic [DATA_WIDTH-1:0]               e_rdata,
	output logic                                s_we,
	output logic [$clog2(MAX_ITEMS)-1:0]        s_waddr,
	output logic [2*$clog2(MAX_ITEMS)-1:0]      s_wdata,
	output logic [$clog2(MAX_ITEMS)-1:0]        s_raddr,
	input  logic [2*$clog2(MAX_ITEMS)-1:0]      s_rdata
);
	import qsm_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	qsm_state_t            state_q;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [CW-1:0]         sp_q;
	logic [1:0]            step_q;
	logic [IW-1:0]         lo_q, hi_q, i_q, j_q, k_q;
	logic [DATA_WIDTH-1:0] va_q, vb_q, vc_q, piv_q, vj_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic                  out_last_q;
	logic                  out_trunc_q;

	logic                  load_fire;
	logic                  room;
	logic [CW-1:0]         n_next;
	logic [IW-1:0]         mid;
	logic [IW-1:0]         j_inc;
	logic [IW-1:0]         lo_gap, hi_gap;
	logic                  push_lo_ok, push_hi_ok;
	logic                  ab_gt, ac_gt, bc_gt;
	logic [DATA_WIDTH-1:0] vmin, vmax, vmed;
	logic [DATA_WIDTH-1:0] vpiv;
	logic                  rd_le_piv;

	assign load_fire = load.valid && load.ready;
	assign room      = count_q < CW'(MAX_ITEMS);
	assign n_next    = room ? (count_q + CW'(1)) : count_q;
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign j_inc     = j_q + IW'(1);
	assign lo_gap    = i_q - lo_q;
	assign hi_gap    = hi_q - i_q;
	assign push_lo_ok = lo_gap > IW'(1);
	assign push_hi_ok = hi_gap > IW'(1);
	assign rd_le_piv = $signed(e_rdata) <= $signed(piv_q);

	// Median of three from parallel compares; the middle value is what remains
	// once the smallest and largest are taken out.
	assign ab_gt = $signed(va_q) > $signed(vb_q);
	assign ac_gt = $signed(va_q) > $signed(vc_q);
	assign bc_gt = $signed(vb_q) > $signed(vc_q);
	assign vmin  = (!ab_gt && !ac_gt) ? va_q : (!bc_gt ? vb_q : vc_q);
	assign vmax  = (ab_gt && ac_gt) ? va_q : (bc_gt ? vb_q : vc_q);
	assign vmed  = va_q ^ vb_q ^ vc_q ^ vmin ^ vmax;

	// On a two-element range the middle entry is the first one, so the first entry
	// ends up with the larger value and the smaller one is left at the top as pivot.
	assign vpiv  = (mid == lo_q) ? vmin : vmed;

	assign load.ready          = (state_q == ST_LOAD);
	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_value_q;
	assign result.last_out     = out_last_q;
	assign result.truncated    = out_trunc_q;

	always_comb begin
		e_we    = 1'b0;
		e_waddr = count_q[IW-1:0];
		e_wdata = load.value;
		e_raddr = '0;
		s_we    = 1'b0;
		s_waddr = sp_q[IW-1:0];
		s_wdata = {lo_q, IW'(i_q - IW'(1))};
		s_raddr = IW'(sp_q - CW'(1));
		case (state_q)
			ST_LOAD: begin
				e_we    = load_fire && room;
				s_we    = load_fire && load.is_last && (n_next >= CW'(2));
				s_waddr = '0;
				s_wdata = {IW'(0), IW'(n_next - CW'(1))};
			end
			ST_M_RD: begin
				case (step_q)
					2'd0:    e_raddr = lo_q;
					2'd1:    e_raddr = mid;
					default: e_raddr = hi_q;
				endcase
			end
			ST_M_WR: begin
				e_we = 1'b1;
				case (step_q)
					2'd0: begin
						e_waddr = lo_q;
						e_wdata = vmin;
					end
					2'd1: begin
						e_waddr = mid;
						e_wdata = vmax;
					end
					default: begin
						e_waddr = hi_q;
						e_wdata = vpiv;
					end
				endcase
			end
			ST_P_RD:  e_raddr = j_q;
			ST_P_CMP: e_raddr = i_q;
			ST_P_SW1: begin
				e_we    = 1'b1;
				e_waddr = j_q;
				e_wdata = e_rdata;
			end
			ST_P_SW2: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				e_wdata = vj_q;
			end
			ST_F_RD: e_raddr = i_q;
			ST_F_SW: begin
				e_we    = 1'b1;
				e_waddr = hi_q;
				e_wdata = e_rdata;
			end
			ST_F_WR: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				e_wdata = piv_q;
				s_we    = push_lo_ok;
			end
			ST_PUSH: begin
				s_we    = push_hi_ok;
				s_wdata = {IW'(i_q + IW'(1)), hi_q};
			end
			ST_E_RD: e_raddr = k_q;
			default: e_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sp_q        <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_fire) begin
						count_q <= n_next;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (load.is_last) begin
							k_q <= '0;
							if (n_next >= CW'(2)) begin
								sp_q    <= CW'(1);
								state_q <= ST_POP;
							end else begin
								state_q <= ST_E_RD;
							end
						end
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						k_q     <= '0;
						state_q <= ST_E_RD;
					end else begin
						sp_q    <= sp_q - CW'(1);
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					lo_q    <= s_rdata[2*IW-1:IW];
					hi_q    <= s_rdata[IW-1:0];
					step_q  <= '0;
					state_q <= ST_M_RD;
				end
				ST_M_RD: begin
					case (step_q)
						2'd1:    va_q <= e_rdata;
						2'd2:    vb_q <= e_rdata;
						2'd3:    vc_q <= e_rdata;
						default: ;
					endcase
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						step_q  <= '0;
						state_q <= ST_M_WR;
					end
				end
				ST_M_WR: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						step_q  <= '0;
						piv_q   <= vpiv;
						i_q     <= lo_q;
						j_q     <= lo_q;
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: state_q <= ST_P_CMP;
				ST_P_CMP: begin
					vj_q <= e_rdata;
					if (rd_le_piv && (i_q != j_q)) begin
						state_q <= ST_P_SW1;
					end else begin
						if (rd_le_piv) begin
							i_q <= i_q + IW'(1);
						end
						j_q     <= j_inc;
						state_q <= (j_inc == hi_q) ? ST_F_RD : ST_P_RD;
					end
				end
				ST_P_SW1: state_q <= ST_P_SW2;
				ST_P_SW2: begin
					i_q     <= i_q + IW'(1);
					j_q     <= j_inc;
					state_q <= (j_inc == hi_q) ? ST_F_RD : ST_P_RD;
				end
				ST_F_RD: state_q <= ST_F_SW;
				ST_F_SW: state_q <= ST_F_WR;
				ST_F_WR: begin
					if (push_lo_ok) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_hi_ok) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= ST_POP;
				end
				ST_E_RD: state_q <= ST_E_LD;
				ST_E_LD: begin
					out_valid_q <= 1'b1;
					out_value_q <= e_rdata;
					out_last_q  <= (CW'(k_q) + CW'(1)) == count_q;
					out_trunc_q <= ovf_q;
					state_q     <= ST_E_HOLD;
				end
				ST_E_HOLD: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							sp_q    <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_E_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`include "quicksort_median_of_three_assert.svh"

	`QSM_ASSERT_IMPL(a_no_result_while_loading, state_q == ST_LOAD, !out_valid_q)
	`QSM_ASSERT_IMPL(a_partition_order, state_q == ST_P_RD, (lo_q <= i_q) && (i_q <= j_q) && (j_q < hi_q))
	`QSM_ASSERT_NEXT(a_last_beat_rearms, out_valid_q && result.ready && out_last_q, (state_q == ST_LOAD) && (count_q == '0) && !ovf_q)
	`QSM_ASSERT_ALWAYS(a_stack_bound, sp_q <= CW'(MAX_ITEMS))

endmodule

@@ tb/quicksort_median_of_three_tb.sv @@
module quicksort_median_of_three_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qsm_pkg::*;

	localparam int DW          = QSM_DATA_WIDTH;
	localparam int CAPACITY    = QSM_MAX_ITEMS;
	localparam int RANDOM_BEATS = 330;
	localparam int MAX_WAIT    = 18;
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic signed [DW-1:0] MOST_NEGATIVE = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] MOST_POSITIVE = {1'b0, {(DW-1){1'b1}}};

	// Ways of filling a set with values.
	typedef enum int {
		FILL_RANDOM,
		FILL_NARROW,
		FILL_EXTREME,
		FILL_RISING,
		FILL_FALLING,
		FILL_FLAT
	} fill_style_t;

	typedef struct packed {
		logic signed [DW-1:0] value;
		logic                 is_last;
	} load_beat_t;

	typedef struct packed {
		logic signed [DW-1:0] sorted_value;
		logic                 last_out;
		logic                 truncated;
	} sorted_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	qsm_load_if   load_ch ();
	qsm_result_if sorted_ch ();

	quicksort_median_of_three dut (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_ch),
		.result (sorted_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Beats still to be offered on the load side, filled up front by the stimulus process.
	load_beat_t   load_pending[$];
	// Sorted beats that the block owes us, oldest first.
	sorted_beat_t sorted_due[$];

	// Our own copy of the set being collected, kept exactly as the block should keep it.
	logic signed [DW-1:0] set_store [CAPACITY];
	int                   set_size;
	logic                 set_dropped;

	// Handshake bookkeeping between the rising-edge monitor and the falling-edge drivers.
	logic load_fired;
	logic sorted_fired;
	int   load_hold;
	int   sink_hold;
	logic load_calm;
	logic sink_calm;

	int cycle_count;
	int fault_count;

	// A calm stretch means back-to-back beats; otherwise anything from 0 to the longest wait.
	function automatic int draw_wait(logic calm);
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void report_fault(string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("sorted beat mismatch: %s", msg);
		end
	endfunction

	function automatic void swap_entries(int a, int b);
		logic signed [DW-1:0] held;
		held         = set_store[a];
		set_store[a] = set_store[b];
		set_store[b] = held;
	endfunction

	// Quicksort of the collected set in place. Each range gets a median-of-three pivot: the
	// first, middle and last entries are put in order, the median is parked at the top, and a
	// Lomuto pass moves everything not greater than it to the low side. Pending ranges live on
	// an explicit stack rather than in recursion.
	function automatic void sort_set();
		int                   span_lo[$];
		int                   span_hi[$];
		int                   lo;
		int                   hi;
		int                   mid;
		int                   place;
		logic signed [DW-1:0] pivot;
		if (set_size >= 2) begin
			span_lo.push_back(0);
			span_hi.push_back(set_size - 1);
		end
		while (span_lo.size() > 0) begin
			lo  = span_lo.pop_back();
			hi  = span_hi.pop_back();
			mid = lo + (hi - lo) / 2;
			if (set_store[lo] > set_store[mid]) swap_entries(lo, mid);
			if (set_store[lo] > set_store[hi]) swap_entries(lo, hi);
			if (set_store[mid] > set_store[hi]) swap_entries(mid, hi);
			swap_entries(mid, hi);
			pivot = set_store[hi];
			place = lo;
			for (int j = lo; j < hi; j++) begin
				if (set_store[j] <= pivot) begin
					swap_entries(place, j);
					place++;
				end
			end
			swap_entries(place, hi);
			// Ranges of fewer than two entries are already in order and never pushed.
			if (place - 1 > lo) begin
				span_lo.push_back(lo);
				span_hi.push_back(place - 1);
			end
			if (place + 1 < hi) begin
				span_lo.push_back(place + 1);
				span_hi.push_back(hi);
			end
		end
	endfunction

	// Account for one accepted load beat. A beat that finds the store full is dropped and
	// marks the set as truncated; that holds for the closing beat too, which still sorts and
	// sends whatever was stored.
	function automatic void absorb_beat(logic signed [DW-1:0] value, logic is_last);
		sorted_beat_t owed;
		if (set_size < CAPACITY) begin
			set_store[set_size] = value;
			set_size++;
		end else begin
			set_dropped = 1'b1;
		end
		if (is_last) begin
			sort_set();
			for (int k = 0; k < set_size; k++) begin
				owed.sorted_value = set_store[k];
				owed.last_out     = (k == set_size - 1);
				owed.truncated    = set_dropped;
				sorted_due.push_back(owed);
			end
			set_size    = 0;
			set_dropped = 1'b0;
		end
	endfunction

	function automatic void queue_beat(logic signed [DW-1:0] value, logic is_last);
		load_beat_t beat;
		beat.value   = value;
		beat.is_last = is_last;
		load_pending.push_back(beat);
	endfunction

	// Queue one whole set of n beats, the final one closing the set.
	function automatic void queue_set(int n, fill_style_t style);
		logic signed [DW-1:0] value;
		logic signed [DW-1:0] flat_value;
		int                   bit_pos;
		flat_value = $urandom();
		for (int k = 0; k < n; k++) begin
			case (style)
				FILL_RANDOM: begin
					value = $urandom();
				end
				FILL_NARROW: begin
					// A tiny range forces plenty of repeated values.
					value = $signed($urandom_range(0, 8)) - 4;
				end
				FILL_EXTREME: begin
					bit_pos = $urandom_range(0, DW - 1);
					case ($urandom_range(0, 5))
						0:       value = MOST_NEGATIVE;
						1:       value = MOST_POSITIVE;
						2:       value = '0;
						3:       value = '1;
						4:       value = 1;
						default: value = MOST_POSITIVE ^ (1 << bit_pos);
					endcase
				end
				FILL_RISING: begin
					value = k * 7 - 20;
				end
				FILL_FALLING: begin
					value = 1000 - k * 13;
				end
				default: begin
					value = flat_value;
				end
			endcase
			queue_beat(value, k == n - 1);
		end
	endfunction

	// Rising edge: count cycles, note which handshakes completed, feed the predictor with
	// accepted load beats and check every sorted beat against the oldest one owed.
	always @(posedge clk) begin
		sorted_beat_t want;
		cycle_count  <= cycle_count + 1;
		load_fired   <= arst_n && load_ch.valid && load_ch.ready;
		sorted_fired <= arst_n && sorted_ch.valid && sorted_ch.ready;
		if (arst_n && load_ch.valid && load_ch.ready) begin
			absorb_beat(load_ch.value, load_ch.is_last);
		end
		if (arst_n && sorted_ch.valid && sorted_ch.ready) begin
			if (sorted_due.size() == 0) begin
				report_fault($sformatf("beat with value %0d arrived with nothing owed",
					sorted_ch.sorted_value));
			end else begin
				want = sorted_due.pop_front();
				if (sorted_ch.sorted_value !== want.sorted_value) begin
					report_fault($sformatf("sorted_value expected %0d, got %0d",
						want.sorted_value, sorted_ch.sorted_value));
				end
				if (sorted_ch.last_out !== want.last_out) begin
					report_fault($sformatf("last_out expected %0b, got %0b",
						want.last_out, sorted_ch.last_out));
				end
				if (sorted_ch.truncated !== want.truncated) begin
					report_fault($sformatf("truncated expected %0b, got %0b",
						want.truncated, sorted_ch.truncated));
				end
			end
		end
	end

	// Load driver, falling edge. A new beat is offered only once the current one has been
	// taken (or none is on offer), after the wait drawn for it has run out. Every path gives
	// valid exactly one assignment, so a beat followed at once by another keeps valid high.
	always @(negedge clk) begin
		if (arst_n && (!load_ch.valid || load_fired)) begin
			if (load_hold > 0) begin
				load_ch.valid <= 1'b0;
				load_hold     <= load_hold - 1;
			end else if (load_pending.size() > 0) begin
				load_ch.valid   <= 1'b1;
				load_ch.value   <= load_pending[0].value;
				load_ch.is_last <= load_pending[0].is_last;
				load_pending.delete(0);
				load_hold <= draw_wait(load_calm);
				if ($urandom_range(0, 31) == 0) begin
					load_calm <= !load_calm;
				end
			end else begin
				load_ch.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, falling edge. After each sorted beat ready drops for a drawn
	// number of cycles, so stalls land on the first, middle and closing beats of a set alike.
	always @(negedge clk) begin
		if (arst_n && (!sorted_ch.ready || sorted_fired)) begin
			if (sink_hold > 0) begin
				sorted_ch.ready <= 1'b0;
				sink_hold       <= sink_hold - 1;
			end else begin
				sorted_ch.ready <= 1'b1;
				sink_hold       <= draw_wait(sink_calm);
				if ($urandom_range(0, 31) == 0) begin
					sink_calm <= !sink_calm;
				end
			end
		end
	end

	// Watchdog: a run that has not finished by the limit is a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("quicksort_median_of_three regression: fail");
		$finish;
	end

	initial begin
		int          random_beats;
		int          n;
		fill_style_t style;

		// Everything the block sees is known from time zero.
		arst_n          = 1'b0;
		load_ch.valid   = 1'b0;
		load_ch.value   = '0;
		load_ch.is_last = 1'b0;
		sorted_ch.ready = 1'b0;
		load_fired      = 1'b0;
		sorted_fired    = 1'b0;
		load_hold       = 0;
		sink_hold       = 0;
		load_calm       = 1'b0;
		sink_calm       = 1'b0;
		cycle_count     = 0;
		fault_count     = 0;
		set_size        = 0;
		set_dropped     = 1'b0;

		// Directed sets: a lone element, the extremes of the range with repeats, a flat set,
		// already ordered and reverse ordered sets, and the smallest set that needs a split.
		queue_beat(MOST_NEGATIVE, 1'b1);
		queue_beat(MOST_POSITIVE, 1'b0);
		queue_beat(MOST_NEGATIVE, 1'b0);
		queue_beat('0, 1'b0);
		queue_beat('1, 1'b0);
		queue_beat(1, 1'b0);
		queue_beat(MOST_POSITIVE, 1'b0);
		queue_beat(MOST_NEGATIVE, 1'b1);
		queue_set(4, FILL_FLAT);
		queue_set(5, FILL_RISING);
		queue_set(5, FILL_FALLING);
		queue_set(2, FILL_EXTREME);

		// Random sets. A completely full set and one that overflows, its closing beat among
		// the dropped ones, come first so that both are always covered; after that, mostly
		// short sets with the odd full or overflowing one.
		queue_set(CAPACITY, FILL_RANDOM);
		queue_set(CAPACITY + 2, style.first());
		random_beats = 2 * CAPACITY + 2;
		while (random_beats < RANDOM_BEATS) begin
			case ($urandom_range(0, 15))
				0:       n = CAPACITY;
				1:       n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
				default: n = $urandom_range(1, 12);
			endcase
			style = fill_style_t'($urandom_range(0, 5));
			queue_set(n, style);
			random_beats += n;
		end

		// Hold reset, then let it go away from the sampling edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to be taken, then for every sorted beat owed, then a little
		// longer in case the block sends anything it should not.
		while (load_pending.size() != 0 || load_ch.valid) @(posedge clk);
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0 && sorted_due.size() == 0) begin
			$display("quicksort_median_of_three regression: pass");
		end else begin
			$display("quicksort_median_of_three regression: fail");
		end
		$finish;
	end

endmodule
